/* design/bpd_pkg.sv */
package bpd_pkg;

	localparam int W         = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIMS      = 3;
	localparam int C_W       = 17;
	localparam int DRAG_W    = 31;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_LANES = 4;
	localparam int DIV_STEPS = W;
	localparam int SQ_STEPS  = W;

	typedef logic signed [W-1:0]   q_t;
	typedef q_t [2:0]              vec_t;
	typedef logic [2*W-1:0]        wide_t;
	typedef wide_t [3:0]           sq_t;
	typedef logic signed [W+3:0]   acc_t;

	localparam q_t QMAX   = {1'b0, {(W-1){1'b1}}};
	localparam q_t QMIN   = {1'b1, {(W-1){1'b0}}};
	localparam q_t Q_ONE  = q_t'(64'd1 << FRAC_BITS);
	localparam q_t Q_TWO  = q_t'(64'd2 << FRAC_BITS);
	localparam q_t Q_HALF = q_t'(64'd1 << (FRAC_BITS - 1));

	localparam logic [C_W-1:0]    LIGHT_SPEED_RST = 17'd29491;
	localparam q_t                QM_RST          = Q_ONE;
	localparam logic [DRAG_W-1:0] DRAG_RST        = '0;
	localparam q_t                FRONT_RST       = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIGHT_SPEED = 2'd0,
		CFG_QM          = 2'd1,
		CFG_DRAG        = 2'd2,
		CFG_FRONT       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		q_t pos_x;
		q_t pos_y;
		q_t pos_z;
		q_t vel_x;
		q_t vel_y;
		q_t vel_z;
		q_t field_ex;
		q_t field_ey;
		q_t field_ez;
		q_t field_bx;
		q_t field_by;
		q_t field_bz;
	} in_t;

	typedef struct packed {
		q_t new_pos_x;
		q_t new_pos_y;
		q_t new_pos_z;
		q_t new_vel_x;
		q_t new_vel_y;
		q_t new_vel_z;
	} out_t;

	// per-particle working set carried down the pipe
	typedef struct packed {
		vec_t pos;
		vec_t vel;
		vec_t e;
		vec_t u;
		vec_t b;
		vec_t p;
		vec_t q;
		vec_t t;
		vec_t u1;
		vec_t u2;
		vec_t nv;
		q_t   f;
		q_t   g2;
		q_t   aux;
		sq_t  sq;
		logic front;
	} item_t;

	// one divider lane: partial remainder, dividend bits shifting out / quotient in
	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] nq;
		logic [W-1:0] den;
		logic         neg;
		logic         ovf;
		logic         nz;
	} dlane_t;

	function automatic q_t sat_q(input acc_t v);
		acc_t hi;
		acc_t lo;
		q_t   r;
		hi = QMAX;
		lo = QMIN;
		if (v > hi) r = QMAX;
		else if (v < lo) r = QMIN;
		else r = q_t'(v);
		return r;
	endfunction

	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [2*W-1:0] ae;
		logic signed [2*W-1:0] be;
		logic signed [2*W-1:0] hw;
		logic signed [2*W-1:0] p;
		logic signed [2*W-1:0] wmax;
		logic signed [2*W-1:0] wmin;
		q_t r;
		ae   = a;
		be   = b;
		hw   = Q_HALF;
		wmax = QMAX;
		wmin = QMIN;
		p    = (ae * be + hw) >>> FRAC_BITS;
		if (p > wmax) r = QMAX;
		else if (p < wmin) r = QMIN;
		else r = q_t'(p);
		return r;
	endfunction

	function automatic q_t half(input q_t a);
		return qmul(a, Q_HALF);
	endfunction

	function automatic wide_t sq64(input q_t x);
		logic signed [2*W-1:0] xe;
		xe = x;
		return wide_t'(xe * xe);
	endfunction

	function automatic wide_t sum_sq(input sq_t s);
		logic [2*W+1:0] t;
		t = {2'b00, s[0]} + {2'b00, s[1]} + {2'b00, s[2]} + {2'b00, s[3]};
		return (t[2*W+1:2*W] != 2'b00) ? {(2*W){1'b1}} : t[2*W-1:0];
	endfunction

	function automatic q_t ext_c(input logic [C_W-1:0] c);
		return q_t'({{(W-C_W){1'b0}}, c});
	endfunction

endpackage

/* design/bpd_in_if.sv */
interface bpd_in_if;
	logic          valid;
	logic          ready;
	bpd_pkg::in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/bpd_out_if.sv */
interface bpd_out_if;
	logic          valid;
	logic          ready;
	bpd_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/boris_push_radiation_drag_core.sv */
// relativistic boris pusher with radiation drag, signed q16.16 throughout. one particle request
// enters per clock and one result leaves per clock while results are taken; it is made of 23
// arithmetic register stages (one multiplier deep each), two 32-stage square root units (one
// root bit per stage) and four 34-stage divider units (one quotient bit per stage plus entry and
// exit). the whole pipe advances together: when the result is held off, every stage holds and
// the input ready drops, nothing is lost or repeated. configuration is a plain write port and
// should only be written while no particle is in flight
module boris_push_radiation_drag_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpd_pkg::CFG_W-1:0]           cfg_data,
	bpd_in_if.sink                              particle,
	bpd_out_if.source                           result
);

	localparam int W = bpd_pkg::W;
	localparam int L = bpd_pkg::DIV_LANES;

	// configuration registers
	logic [bpd_pkg::C_W-1:0]    light_speed_q;
	bpd_pkg::q_t                qm_q;
	logic [bpd_pkg::DRAG_W-1:0] drag_q;
	bpd_pkg::q_t                front_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_speed_q <= bpd_pkg::LIGHT_SPEED_RST;
			qm_q          <= bpd_pkg::QM_RST;
			drag_q        <= bpd_pkg::DRAG_RST;
			front_q       <= bpd_pkg::FRONT_RST;
		end else if (cfg_wr_en) begin
			case (bpd_pkg::cfg_idx_t'(cfg_index))
				bpd_pkg::CFG_LIGHT_SPEED: light_speed_q <= cfg_data[bpd_pkg::C_W-1:0];
				bpd_pkg::CFG_QM:          qm_q          <= bpd_pkg::q_t'(cfg_data);
				bpd_pkg::CFG_DRAG:        drag_q        <= cfg_data[bpd_pkg::DRAG_W-1:0];
				bpd_pkg::CFG_FRONT:       front_q       <= bpd_pkg::q_t'(cfg_data);
				default: ;
			endcase
		end
	end

	bpd_pkg::q_t  cq;
	logic [W-1:0] cu;
	bpd_pkg::q_t  dq;
	assign cq = bpd_pkg::ext_c(light_speed_q);
	assign cu = {{(W-bpd_pkg::C_W){1'b0}}, light_speed_q};
	assign dq = bpd_pkg::q_t'({1'b0, drag_q});

	// global advance: the last stage is the output register
	logic en;
	logic v_s23;
	assign en             = !v_s23 || result.ready;
	assign particle.ready = en;

	bpd_pkg::vec_t pin, vin, ein, bin;
	assign pin = {particle.data.pos_z, particle.data.pos_y, particle.data.pos_x};
	assign vin = {particle.data.vel_z, particle.data.vel_y, particle.data.vel_x};
	assign ein = {particle.data.field_ez, particle.data.field_ey, particle.data.field_ex};
	assign bin = {particle.data.field_bz, particle.data.field_by, particle.data.field_bx};

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20, v_s21, v_s22;
	bpd_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8, it_s9;
	bpd_pkg::item_t it_s10, it_s11, it_s12, it_s13, it_s14, it_s15, it_s16, it_s17;
	bpd_pkg::item_t it_s18, it_s19, it_s20, it_s21, it_s22;
	bpd_pkg::wide_t sum_s5, sum_s15;
	bpd_pkg::out_t  res_s23;

	// unit outputs
	logic                     v_r1, v_r2, v_d1, v_d2, v_d3, v_d4;
	logic [W-1:0]             root_r1, root_r2;
	bpd_pkg::item_t           it_r1, it_r2, it_d1, it_d2, it_d3, it_d4;
	bpd_pkg::q_t [L-1:0]      quo_d1, quo_d2, quo_d3, quo_d4;
	bpd_pkg::q_t [L-1:0]      num_d1, num_d2, num_d3, num_d4;
	logic [L-1:0][W-1:0]      den_d1, den_d2, den_d3, den_d4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0; v_s5  <= 1'b0;
			v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0; v_s20 <= 1'b0;
			v_s21 <= 1'b0; v_s22 <= 1'b0; v_s23 <= 1'b0;
		end else if (en) begin
			v_s1  <= particle.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_d1;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_d2;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_d3;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_d4;
			v_s21 <= v_s20;
			v_s22 <= v_s21;
			v_s23 <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: scale fields by charge over mass, note beam front side
			it_s1       <= '0;
			it_s1.pos   <= pin;
			it_s1.vel   <= vin;
			it_s1.front <= (particle.data.pos_x <= front_q);
			for (int i = 0; i < 3; i++) begin
				it_s1.e[i] <= bpd_pkg::qmul(ein[i], qm_q);
				it_s1.b[i] <= bpd_pkg::qmul(bin[i], qm_q);
			end

			// s2: half kicks, momentum from four-velocity
			it_s2 <= it_s1;
			for (int i = 0; i < 3; i++) begin
				it_s2.e[i] <= bpd_pkg::half(it_s1.e[i]);
				it_s2.b[i] <= bpd_pkg::half(it_s1.b[i]);
				it_s2.u[i] <= bpd_pkg::qmul(it_s1.vel[i], cq);
			end

			// s3: first half electric kick
			it_s3 <= it_s2;
			for (int i = 0; i < 3; i++)
				it_s3.u[i] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s2.u[i]) +
					bpd_pkg::acc_t'(it_s2.e[i]));

			// s4/s5: exact squares and saturating sum for gamma
			it_s4       <= it_s3;
			it_s4.sq[0] <= bpd_pkg::sq64(cq);
			for (int i = 0; i < 3; i++) it_s4.sq[i+1] <= bpd_pkg::sq64(it_s3.u[i]);
			it_s5  <= it_s4;
			sum_s5 <= bpd_pkg::sum_sq(it_s4.sq);

			// s6: rotation vector scaled by 1/gamma
			it_s6 <= it_d1;
			for (int i = 0; i < 3; i++) it_s6.b[i] <= bpd_pkg::qmul(quo_d1[i], quo_d1[3]);

			// s7/s8: 1 + |b|^2
			it_s7 <= it_s6;
			for (int i = 0; i < 3; i++) it_s7.p[i] <= bpd_pkg::qmul(it_s6.b[i], it_s6.b[i]);
			it_s8     <= it_s7;
			it_s8.aux <= bpd_pkg::sat_q(bpd_pkg::acc_t'(bpd_pkg::Q_ONE) +
				bpd_pkg::acc_t'(it_s7.p[0]) + bpd_pkg::acc_t'(it_s7.p[1]) +
				bpd_pkg::acc_t'(it_s7.p[2]));

			// s9..s11: u1 = (u + u x b) * f
			it_s9   <= it_d2;
			it_s9.f <= quo_d2[0];
			for (int i = 0; i < 3; i++) begin
				it_s9.p[i] <= bpd_pkg::qmul(it_d2.u[(i+1)%3], it_d2.b[(i+2)%3]);
				it_s9.q[i] <= bpd_pkg::qmul(it_d2.u[(i+2)%3], it_d2.b[(i+1)%3]);
			end
			it_s10 <= it_s9;
			for (int i = 0; i < 3; i++)
				it_s10.t[i] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s9.u[i]) +
					bpd_pkg::acc_t'(it_s9.p[i]) - bpd_pkg::acc_t'(it_s9.q[i]));
			it_s11 <= it_s10;
			for (int i = 0; i < 3; i++) it_s11.u1[i] <= bpd_pkg::qmul(it_s10.t[i], it_s10.f);

			// s12/s13: u2 = u + u1 x b + e
			it_s12 <= it_s11;
			for (int i = 0; i < 3; i++) begin
				it_s12.p[i] <= bpd_pkg::qmul(it_s11.u1[(i+1)%3], it_s11.b[(i+2)%3]);
				it_s12.q[i] <= bpd_pkg::qmul(it_s11.u1[(i+2)%3], it_s11.b[(i+1)%3]);
			end
			it_s13 <= it_s12;
			for (int i = 0; i < 3; i++)
				it_s13.u2[i] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s12.u[i]) +
					bpd_pkg::acc_t'(it_s12.p[i]) - bpd_pkg::acc_t'(it_s12.q[i]) +
					bpd_pkg::acc_t'(it_s12.e[i]));

			// s14/s15: squares for the second gamma
			it_s14       <= it_s13;
			it_s14.sq[0] <= bpd_pkg::sq64(cq);
			for (int i = 0; i < 3; i++) it_s14.sq[i+1] <= bpd_pkg::sq64(it_s13.u2[i]);
			it_s15  <= it_s14;
			sum_s15 <= bpd_pkg::sum_sq(it_s14.sq);

			// s16..s19: new velocity, drag denominator 1 + uxt^2
			it_s16      <= it_d3;
			it_s16.g2   <= quo_d3[3];
			it_s16.aux  <= bpd_pkg::qmul(cq, dq);
			it_s16.t[0] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(quo_d3[0]) +
				bpd_pkg::acc_t'(it_d3.vel[0]));
			for (int i = 0; i < 3; i++) it_s16.nv[i] <= quo_d3[i];
			it_s17      <= it_s16;
			it_s17.t[0] <= bpd_pkg::half(it_s16.t[0]);
			it_s18      <= it_s17;
			it_s18.t[1] <= bpd_pkg::qmul(it_s17.t[0], it_s17.t[0]);
			it_s19      <= it_s18;
			it_s19.t[2] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(bpd_pkg::Q_ONE) +
				bpd_pkg::acc_t'(it_s18.t[1]));

			// s20: radiation push only at or behind the beam front
			it_s20 <= it_d4;
			if (it_d4.front)
				it_s20.nv[0] <= bpd_pkg::sat_q(bpd_pkg::acc_t'(it_d4.nv[0]) +
					bpd_pkg::acc_t'(quo_d4[0]));

			// s21..s23: position advance by vel * c / gamma
			it_s21 <= it_s20;
			for (int i = 0; i < 3; i++) it_s21.p[i] <= bpd_pkg::qmul(it_s20.nv[i], it_s20.g2);
			it_s22 <= it_s21;
			for (int i = 0; i < 3; i++) it_s22.q[i] <= bpd_pkg::qmul(it_s21.p[i], cq);

			res_s23.new_vel_x <= it_s22.nv[0];
			res_s23.new_vel_y <= it_s22.nv[1];
			res_s23.new_vel_z <= it_s22.nv[2];
			res_s23.new_pos_x <= bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s22.pos[0]) +
				bpd_pkg::acc_t'(it_s22.q[0]));
			res_s23.new_pos_y <= (bpd_pkg::DIMS >= 2) ?
				bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s22.pos[1]) + bpd_pkg::acc_t'(it_s22.q[1])) :
				it_s22.pos[1];
			res_s23.new_pos_z <= (bpd_pkg::DIMS >= 3) ?
				bpd_pkg::sat_q(bpd_pkg::acc_t'(it_s22.pos[2]) + bpd_pkg::acc_t'(it_s22.q[2])) :
				it_s22.pos[2];
		end
	end

	assign result.valid = v_s23;
	assign result.data  = res_s23;

	// first gamma root
	bpd_sqrt u_sqrt1 (
		.clk, .arst_n, .en,
		.v_in(v_s5), .val(sum_s5), .it_in(it_s5),
		.v_out(v_r1), .root(root_r1), .it_out(it_r1)
	);

	// b / c on three lanes, c / root for 1/gamma on the fourth
	assign num_d1 = {cq, it_r1.b[2], it_r1.b[1], it_r1.b[0]};
	assign den_d1 = {root_r1, cu, cu, cu};

	bpd_div u_div1 (
		.clk, .arst_n, .en,
		.v_in(v_r1), .num(num_d1), .den(den_d1), .it_in(it_r1),
		.v_out(v_d1), .quo(quo_d1), .it_out(it_d1)
	);

	// rotation factor 2 / (1 + |b|^2), denominator is at least one
	assign num_d2 = {bpd_pkg::q_t'(0), bpd_pkg::q_t'(0), bpd_pkg::q_t'(0), bpd_pkg::Q_TWO};
	assign den_d2 = {{(3*W){1'b0}}, W'(it_s8.aux)};

	bpd_div u_div2 (
		.clk, .arst_n, .en,
		.v_in(v_s8), .num(num_d2), .den(den_d2), .it_in(it_s8),
		.v_out(v_d2), .quo(quo_d2), .it_out(it_d2)
	);

	// second gamma root from u2
	bpd_sqrt u_sqrt2 (
		.clk, .arst_n, .en,
		.v_in(v_s15), .val(sum_s15), .it_in(it_s15),
		.v_out(v_r2), .root(root_r2), .it_out(it_r2)
	);

	// u2 / c on three lanes, 1/gamma of u2 on the fourth
	assign num_d3 = {cq, it_r2.u2[2], it_r2.u2[1], it_r2.u2[0]};
	assign den_d3 = {root_r2, cu, cu, cu};

	bpd_div u_div3 (
		.clk, .arst_n, .en,
		.v_in(v_r2), .num(num_d3), .den(den_d3), .it_in(it_r2),
		.v_out(v_d3), .quo(quo_d3), .it_out(it_d3)
	);

	// drag push c*drag / (1 + uxt^2)
	assign num_d4 = {bpd_pkg::q_t'(0), bpd_pkg::q_t'(0), bpd_pkg::q_t'(0), it_s19.aux};
	assign den_d4 = {{(3*W){1'b0}}, W'(it_s19.t[2])};

	bpd_div u_div4 (
		.clk, .arst_n, .en,
		.v_in(v_s19), .num(num_d4), .den(den_d4), .it_in(it_s19),
		.v_out(v_d4), .quo(quo_d4), .it_out(it_d4)
	);

	a_rot_den_ge_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> it_s8.aux >= bpd_pkg::Q_ONE)
		else $error("rotation denominator below one");

	a_drag_den_ge_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s19 |-> it_s19.t[2] >= bpd_pkg::Q_ONE)
		else $error("drag denominator below one");

	a_no_push_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_d4 && !it_d4.front |=> it_s20.nv[0] == $past(it_d4.nv[0]))
		else $error("radiation push applied ahead of the beam front");

endmodule

/* design/bpd_sqrt.sv */
module bpd_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  bpd_pkg::wide_t      val,
	input  bpd_pkg::item_t      it_in,
	output logic                v_out,
	output logic [bpd_pkg::W-1:0] root,
	output bpd_pkg::item_t      it_out
);

	localparam int N = bpd_pkg::SQ_STEPS;

	bpd_pkg::wide_t rem_s [1:N];
	bpd_pkg::wide_t res_s [1:N];
	bpd_pkg::item_t it_s  [1:N];
	logic           v_s   [1:N];

	// one result bit per stage, digit by digit
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam bpd_pkg::wide_t ONE_BIT = bpd_pkg::wide_t'(1) << (2*bpd_pkg::W - 2 - 2*k);
		bpd_pkg::wide_t r_in;
		bpd_pkg::wide_t x_in;
		bpd_pkg::wide_t trial;
		bpd_pkg::item_t i_in;
		logic           vi;

		if (k == 0) begin : g_head
			assign r_in = '0;
			assign x_in = val;
			assign i_in = it_in;
			assign vi   = v_in;
		end else begin : g_tail
			assign r_in = res_s[k];
			assign x_in = rem_s[k];
			assign i_in = it_s[k];
			assign vi   = v_s[k];
		end

		assign trial = r_in + ONE_BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					rem_s[k+1] <= x_in - trial;
					res_s[k+1] <= (r_in >> 1) + ONE_BIT;
				end else begin
					rem_s[k+1] <= x_in;
					res_s[k+1] <= r_in >> 1;
				end
				it_s[k+1] <= i_in;
			end
		end
	end

	assign v_out  = v_s[N];
	assign root   = res_s[N][bpd_pkg::W-1:0];
	assign it_out = it_s[N];

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] |-> (res_s[N][2*bpd_pkg::W-1:bpd_pkg::W] == '0 && rem_s[N] <= (res_s[N] << 1)))
		else $error("root wider than half the radicand or remainder out of range");

endmodule

/* design/bpd_div.sv */
module bpd_div (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          v_in,
	input  bpd_pkg::q_t [bpd_pkg::DIV_LANES-1:0]          num,
	input  logic [bpd_pkg::DIV_LANES-1:0][bpd_pkg::W-1:0] den,
	input  bpd_pkg::item_t                                it_in,
	output logic                                          v_out,
	output bpd_pkg::q_t [bpd_pkg::DIV_LANES-1:0]          quo,
	output bpd_pkg::item_t                                it_out
);

	localparam int N  = bpd_pkg::DIV_STEPS;
	localparam int L  = bpd_pkg::DIV_LANES;
	localparam int W  = bpd_pkg::W;
	localparam int F  = bpd_pkg::FRAC_BITS;

	bpd_pkg::dlane_t [L-1:0] lane_s [0:N];
	bpd_pkg::item_t          it_s   [0:N];
	logic                    v_s    [0:N];
	bpd_pkg::q_t [L-1:0]     quo_q;
	bpd_pkg::item_t          it_q;
	logic                    v_q;

	// entry: magnitudes, early overflow check, upper dividend bits as first remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		logic [W-1:0]     mag;
		logic [2*W-F-1:0] lhs;
		logic [2*W-F-1:0] rhs;
		if (en) begin
			for (int l = 0; l < L; l++) begin
				mag = num[l][W-1] ? (~num[l] + 1'b1) : num[l];
				lhs = {{(W-F){1'b0}}, mag};
				rhs = {den[l], {(W-F){1'b0}}};
				lane_s[0][l].rem <= W'(mag >> (W-F));
				lane_s[0][l].nq  <= mag << F;
				lane_s[0][l].den <= den[l];
				lane_s[0][l].neg <= num[l][W-1];
				lane_s[0][l].ovf <= (lhs >= rhs);
				lane_s[0][l].nz  <= |mag;
			end
			it_s[0] <= it_in;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			logic [W:0] tr;
			logic       ge;
			if (en) begin
				for (int l = 0; l < L; l++) begin
					tr = {lane_s[k][l].rem, lane_s[k][l].nq[W-1]};
					ge = (tr >= {1'b0, lane_s[k][l].den});
					lane_s[k+1][l]     <= lane_s[k][l];
					lane_s[k+1][l].rem <= ge ? W'(tr - {1'b0, lane_s[k][l].den}) : tr[W-1:0];
					lane_s[k+1][l].nq  <= {lane_s[k][l].nq[W-2:0], ge};
				end
				it_s[k+1] <= it_s[k];
			end
		end
	end

	// exit: sign and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (en) v_q <= v_s[N];
	end

	always_ff @(posedge clk) begin
		logic [W-1:0] qm;
		logic [W-1:0] lim;
		if (en) begin
			lim = bpd_pkg::QMIN;
			for (int l = 0; l < L; l++) begin
				qm = lane_s[N][l].nq;
				if (lane_s[N][l].ovf) begin
					if (!lane_s[N][l].nz) quo_q[l] <= '0;
					else quo_q[l] <= lane_s[N][l].neg ? bpd_pkg::QMIN : bpd_pkg::QMAX;
				end else if (lane_s[N][l].neg) begin
					quo_q[l] <= (qm > lim) ? bpd_pkg::QMIN : bpd_pkg::q_t'(~qm + 1'b1);
				end else begin
					quo_q[l] <= qm[W-1] ? bpd_pkg::QMAX : bpd_pkg::q_t'(qm);
				end
			end
			it_q <= it_s[N];
		end
	end

	assign v_out  = v_q;
	assign quo    = quo_q;
	assign it_out = it_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && !lane_s[0][0].ovf |-> lane_s[0][0].rem < lane_s[0][0].den)
		else $error("divider start remainder not below divisor without overflow");

endmodule
